[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CHG_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CHG_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

[sv/chg_pkg.sv]
`default_nettype none

package chg_pkg;

  localparam int CHANNEL_WIDTH   = 1;
  localparam int TICKS_IN_WIDTH  = 32;
  localparam int CFG_WIDTH       = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int MODE_WIDTH      = 3;

  typedef logic [MODE_WIDTH-1:0]      mode_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [CFG_WIDTH-1:0]       cfg_word_t;

  localparam mode_t MODE_OFF       = 3'd0;
  localparam mode_t MODE_COOL_WAIT = 3'd1;
  localparam mode_t MODE_COOLING   = 3'd2;
  localparam mode_t MODE_OVERRUN   = 3'd3;
  localparam mode_t MODE_HEAT_WAIT = 3'd4;
  localparam mode_t MODE_HEATING   = 3'd5;

  localparam cfg_index_t CFG_MIN_COOLING = 2'd0;
  localparam cfg_index_t CFG_MAX_COOLING = 2'd1;
  localparam cfg_index_t CFG_MIN_OFF     = 2'd2;

  localparam cfg_word_t MIN_COOLING_RESET = 32'd180000;
  localparam cfg_word_t MAX_COOLING_RESET = 32'd3600000;
  localparam cfg_word_t MIN_OFF_RESET     = 32'd300000;

endpackage

`default_nettype wire

[sv/chg_ram.sv]
`default_nettype none

module chg_ram #(
  parameter int WIDTH      = 8,
  parameter int DEPTH      = 2,
  parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_WIDTH-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]      wr_data,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_WIDTH-1:0] rd_addr,
  output logic      [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/chg_update.sv]
`default_nettype none

module chg_update
  import chg_pkg::*;
#(
  parameter int TICK_WIDTH = 32
) (
  input  wire mode_t                  cur_mode,
  input  wire logic [TICK_WIDTH-1:0]  cur_cool_start_after,
  input  wire logic [TICK_WIDTH-1:0]  cur_cool_stop_after,
  input  wire logic [TICK_WIDTH-1:0]  cur_cool_stop_by,
  input  wire logic [TICK_WIDTH-1:0]  cur_heat_start_after,
  input  wire logic                   cool,
  input  wire logic                   heat,
  input  wire logic [TICK_WIDTH-1:0]  now,
  input  wire logic [TICK_WIDTH-1:0]  min_cooling,
  input  wire logic [TICK_WIDTH-1:0]  max_cooling,
  input  wire logic [TICK_WIDTH-1:0]  min_off,
  output mode_t                       next_mode,
  output logic      [TICK_WIDTH-1:0]  next_cool_start_after,
  output logic      [TICK_WIDTH-1:0]  next_cool_stop_after,
  output logic      [TICK_WIDTH-1:0]  next_cool_stop_by,
  output logic      [TICK_WIDTH-1:0]  next_heat_start_after
);

  logic [TICK_WIDTH-1:0] off_until;

  // sums wrap at TICK_WIDTH bits
  assign off_until = now + min_off;

  always_comb begin
    next_mode             = cur_mode;
    next_cool_start_after = cur_cool_start_after;
    next_cool_stop_after  = cur_cool_stop_after;
    next_cool_stop_by     = cur_cool_stop_by;
    next_heat_start_after = cur_heat_start_after;
    case (cur_mode)
      MODE_COOL_WAIT: begin
        if (!cool) begin
          next_mode = MODE_OFF;
        end else if (now >= cur_cool_start_after) begin
          next_cool_stop_after = now + min_cooling;
          next_cool_stop_by    = now + max_cooling;
          next_mode            = MODE_COOLING;
        end
      end
      MODE_COOLING: begin
        if (!cool) begin
          next_mode = MODE_OVERRUN;
        end else if (now >= cur_cool_stop_by) begin
          next_cool_start_after = off_until;
          next_heat_start_after = off_until;
          next_mode             = MODE_OFF;
        end
      end
      MODE_OVERRUN: begin
        if (cool) begin
          next_mode = MODE_COOLING;
        end else if (now >= cur_cool_stop_after) begin
          next_cool_start_after = off_until;
          next_heat_start_after = off_until;
          next_mode             = MODE_OFF;
        end
      end
      MODE_HEAT_WAIT: begin
        if (!heat) begin
          next_mode = MODE_OFF;
        end else if (now >= cur_heat_start_after) begin
          next_mode = MODE_HEATING;
        end
      end
      MODE_HEATING: begin
        if (!heat) begin
          next_cool_start_after = off_until;
          next_mode             = MODE_OFF;
        end
      end
      default: begin
        // off, and any stray code; both requests at once keep it off
        next_mode = MODE_OFF;
        if (cool && !heat) begin
          next_mode = MODE_COOL_WAIT;
        end else if (heat && !cool) begin
          next_mode = MODE_HEAT_WAIT;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/compressor_heater_guard_fsm.sv]
// Each accepted input beat passes the lookup stage, then the output register, which holds its result beat.
// Throughput: one beat per cycle while out_stall is low; each channel's state is read from the state RAM
// on accept and written back as the beat leaves the lookup stage, with a bypass for back-to-back beats.
// Reset (rst, synchronous): all channels read as off with zero deadlines (per-entry
// valid bits), timing registers take their default values, both pipeline stages empty.
`default_nettype none

`include "assert_macros.svh"

module compressor_heater_guard_fsm
  import chg_pkg::*;
#(
  parameter int CHANNELS   = 2,
  parameter int TICK_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire cfg_index_t                cfg_index,
  input  wire cfg_word_t                 cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [CHANNEL_WIDTH-1:0]  channel,
  input  wire logic                      cool_request,
  input  wire logic                      heat_request,
  input  wire logic [TICKS_IN_WIDTH-1:0] now_ticks,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [CHANNEL_WIDTH-1:0]  channel_out,
  output mode_t                          mode,
  output logic                           compressor_on,
  output logic                           heater_on
);

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef struct packed {
    mode_t                 mode;
    logic [TICK_WIDTH-1:0] cool_start_after;
    logic [TICK_WIDTH-1:0] cool_stop_after;
    logic [TICK_WIDTH-1:0] cool_stop_by;
    logic [TICK_WIDTH-1:0] heat_start_after;
  } chan_state_t;

  localparam int STATE_WIDTH = $bits(chan_state_t);

  cfg_word_t min_cooling_ticks;
  cfg_word_t max_cooling_ticks;
  cfg_word_t min_off_ticks;

  logic [CHANNELS-1:0] entry_valid;

  logic                     s1_valid;
  logic [CH_AW-1:0]         s1_addr;
  logic                     s1_in_range;
  logic                     s1_entry_valid;
  logic [CHANNEL_WIDTH-1:0] s1_channel;
  logic                     s1_cool;
  logic                     s1_heat;
  logic [TICK_WIDTH-1:0]    s1_now;
  logic                     s1_fwd;
  chan_state_t              s1_fwd_data;

  logic             advance;
  logic             accept;
  logic             commit;
  logic             in_range;
  logic [CH_AW-1:0] in_addr;

  chan_state_t ram_rd;
  chan_state_t cur_state;
  chan_state_t state_next;
  mode_t       mode_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cooling_ticks <= MIN_COOLING_RESET;
      max_cooling_ticks <= MAX_COOLING_RESET;
      min_off_ticks     <= MIN_OFF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIN_COOLING: min_cooling_ticks <= cfg_data;
        CFG_MAX_COOLING: max_cooling_ticks <= cfg_data;
        CFG_MIN_OFF:     min_off_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign commit   = s1_valid && advance && s1_in_range;
  assign in_range = int'(channel) < CHANNELS;
  assign in_addr  = CH_AW'(channel);

  chg_ram #(
    .WIDTH (STATE_WIDTH),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (s1_addr),
    .wr_data (state_next),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (ram_rd)
  );

  // bypass covers a write landing on the same edge as the read
  always_comb begin
    if (s1_fwd) begin
      cur_state = s1_fwd_data;
    end else if (s1_entry_valid) begin
      cur_state = ram_rd;
    end else begin
      cur_state = '0;
    end
  end

  chg_update #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_update (
    .cur_mode              (cur_state.mode),
    .cur_cool_start_after  (cur_state.cool_start_after),
    .cur_cool_stop_after   (cur_state.cool_stop_after),
    .cur_cool_stop_by      (cur_state.cool_stop_by),
    .cur_heat_start_after  (cur_state.heat_start_after),
    .cool                  (s1_cool),
    .heat                  (s1_heat),
    .now                   (s1_now),
    .min_cooling           (TICK_WIDTH'(min_cooling_ticks)),
    .max_cooling           (TICK_WIDTH'(max_cooling_ticks)),
    .min_off               (TICK_WIDTH'(min_off_ticks)),
    .next_mode             (state_next.mode),
    .next_cool_start_after (state_next.cool_start_after),
    .next_cool_stop_after  (state_next.cool_stop_after),
    .next_cool_stop_by     (state_next.cool_stop_by),
    .next_heat_start_after (state_next.heat_start_after)
  );

  assign mode_next = s1_in_range ? state_next.mode : MODE_OFF;

  // lookup stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (commit) begin
        entry_valid[s1_addr] <= 1'b1;
      end
    end
  end

  // lookup stage: payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr        <= in_addr;
      s1_in_range    <= in_range;
      s1_entry_valid <= in_range && entry_valid[in_addr];
      s1_channel     <= channel;
      s1_cool        <= cool_request;
      s1_heat        <= heat_request;
      s1_now         <= TICK_WIDTH'(now_ticks);
      s1_fwd         <= commit && (s1_addr == in_addr);
      s1_fwd_data    <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      channel_out   <= s1_channel;
      mode          <= mode_next;
      compressor_on <= (mode_next == MODE_COOLING) || (mode_next == MODE_OVERRUN);
      heater_on     <= (mode_next == MODE_HEATING);
    end
  end

  `CHG_ASSERT_NOW(a_drives_exclusive, out_valid, !(compressor_on && heater_on), "compressor and heater both on")
  `CHG_ASSERT_NEXT(a_bypass_taken, accept && commit && (s1_addr == in_addr), s1_fwd, "same-entry write not bypassed")
  `CHG_ASSERT_NEXT(a_stage_holds, s1_valid && !advance, s1_valid && $stable(s1_addr), "held beat lost in lookup stage")

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import chg_pkg::*;

  localparam int CHANNEL_COUNT = 2;
  localparam int QUIET_LIMIT   = 3000;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_BEATS  = 440;
  localparam int SEGMENT_BEATS = 110;

  // no register lives at the last index; writes there must be dropped
  localparam cfg_index_t CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHANNEL_WIDTH-1:0] channel;
    mode_t                    mode;
    logic                     compressor_on;
    logic                     heater_on;
  } guard_result_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  cfg_index_t                cfg_index;
  cfg_word_t                 cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [CHANNEL_WIDTH-1:0]  channel;
  logic                      cool_request;
  logic                      heat_request;
  logic [TICKS_IN_WIDTH-1:0] now_ticks;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [CHANNEL_WIDTH-1:0]  channel_out;
  mode_t                     mode;
  logic                      compressor_on;
  logic                      heater_on;

  compressor_heater_guard_fsm u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .channel      (channel),
    .cool_request (cool_request),
    .heat_request (heat_request),
    .now_ticks    (now_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .channel_out  (channel_out),
    .mode         (mode),
    .compressor_on(compressor_on),
    .heater_on    (heater_on)
  );

  always #10 clk = ~clk;

  // guard model state
  cfg_word_t   run_min;
  cfg_word_t   run_max;
  cfg_word_t   rest_min;
  mode_t       chan_mode    [CHANNEL_COUNT];
  logic [31:0] cool_open_at [CHANNEL_COUNT];
  logic [31:0] run_until    [CHANNEL_COUNT];
  logic [31:0] run_cutoff   [CHANNEL_COUNT];
  logic [31:0] heat_open_at [CHANNEL_COUNT];

  guard_result_t pending_results[$];

  int sender_idle_pct;
  int receiver_idle_pct;
  int mismatches;
  int beats_sent;
  int results_seen;
  int reg_writes;
  int quiet_cycles;
  int mode_hits [8];

  function automatic guard_result_t step_guard(input logic [CHANNEL_WIDTH-1:0] c,
                                               input logic cool, input logic heat,
                                               input logic [31:0] now);
    guard_result_t r;
    logic [31:0]   rest_end;
    rest_end = now + rest_min;
    case (chan_mode[c])
      MODE_COOL_WAIT: begin
        if (!cool) begin
          chan_mode[c] = MODE_OFF;
        end else if (now >= cool_open_at[c]) begin
          run_until[c]  = now + run_min;
          run_cutoff[c] = now + run_max;
          chan_mode[c]  = MODE_COOLING;
        end
      end
      MODE_COOLING: begin
        if (!cool) begin
          chan_mode[c] = MODE_OVERRUN;
        end else if (now >= run_cutoff[c]) begin
          cool_open_at[c] = rest_end;
          heat_open_at[c] = rest_end;
          chan_mode[c]    = MODE_OFF;
        end
      end
      // max run time is not enforced here, only the min run time
      MODE_OVERRUN: begin
        if (cool) begin
          chan_mode[c] = MODE_COOLING;
        end else if (now >= run_until[c]) begin
          cool_open_at[c] = rest_end;
          heat_open_at[c] = rest_end;
          chan_mode[c]    = MODE_OFF;
        end
      end
      MODE_HEAT_WAIT: begin
        if (!heat) begin
          chan_mode[c] = MODE_OFF;
        end else if (now >= heat_open_at[c]) begin
          chan_mode[c] = MODE_HEATING;
        end
      end
      MODE_HEATING: begin
        if (!heat) begin
          cool_open_at[c] = rest_end;
          chan_mode[c]    = MODE_OFF;
        end
      end
      default: begin
        if (cool && !heat) chan_mode[c] = MODE_COOL_WAIT;
        else if (heat && !cool) chan_mode[c] = MODE_HEAT_WAIT;
        else chan_mode[c] = MODE_OFF;
      end
    endcase
    r.channel       = c;
    r.mode          = chan_mode[c];
    r.compressor_on = (chan_mode[c] == MODE_COOLING) || (chan_mode[c] == MODE_OVERRUN);
    r.heater_on     = (chan_mode[c] == MODE_HEATING);
    return r;
  endfunction

  function automatic cfg_word_t pick_ticks(input int span);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom_range(span);
    endcase
  endfunction

  task automatic send_beat(input logic [CHANNEL_WIDTH-1:0] c, input logic cool,
                           input logic heat, input logic [31:0] now);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    channel      <= c;
    cool_request <= cool;
    heat_request <= heat;
    now_ticks    <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(step_guard(c, cool, heat, now));
    beats_sent++;
  endtask

  // hold off input until every expected result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_word_t value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_MIN_COOLING: run_min  = value;
      CFG_MAX_COOLING: run_max  = value;
      CFG_MIN_OFF:     rest_min = value;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_beat(0, 1, 0, 32'd0);
    send_beat(0, 1, 0, 32'd0);
    send_beat(1, 0, 1, 32'd5);
    send_beat(1, 0, 1, 32'd5);
    send_beat(0, 1, 0, 32'd3599999);
    send_beat(0, 1, 0, 32'd3600000);  // forced off at max run
    send_beat(0, 1, 0, 32'd3600001);
    send_beat(0, 1, 0, 32'd3900000);
    send_beat(0, 0, 0, 32'd3900100);
    send_beat(0, 1, 0, 32'd3900200);  // overrun back to cooling
    send_beat(0, 0, 0, 32'd3900300);
    send_beat(0, 0, 0, 32'hFFFF_FFFF); // off-time deadline wraps
    send_beat(1, 0, 0, 32'hFFFF_FFFF);
    send_beat(0, 1, 1, 32'd10);       // both requests while off
  endtask

  task automatic test_special_cases();
    send_beat(1, 0, 1, 32'd400000);
    send_beat(1, 1, 1, 32'd400001);   // heat wait with both: heat counts
    send_beat(1, 1, 1, 32'd400002);
    send_beat(1, 1, 0, 32'd400003);
    send_beat(1, 0, 1, 32'd400004);
    send_beat(1, 0, 0, 32'd400005);
    send_beat(0, 1, 1, 32'd400006);
    send_beat(0, 1, 0, 32'd400007);
    send_beat(0, 1, 1, 32'd400008);   // cool wait with both: cool counts
    send_beat(0, 0, 0, 32'd400009);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_MIN_COOLING, '0);
    write_reg(CFG_MAX_COOLING, '0);
    write_reg(CFG_MIN_OFF, '0);
    send_beat(0, 1, 0, 32'hFFFF_FFF0);
    send_beat(0, 1, 0, 32'hFFFF_FFF0);
    send_beat(0, 1, 0, 32'hFFFF_FFF1);
    send_beat(0, 0, 0, 32'hFFFF_FFF2);
    wait_idle();
    write_reg(CFG_MIN_COOLING, '1);
    write_reg(CFG_MAX_COOLING, '1);
    write_reg(CFG_MIN_OFF, '1);
    write_reg(CFG_UNUSED, $urandom());
    send_beat(1, 0, 1, 32'h8000_0000);
    send_beat(1, 0, 1, 32'h8000_0000);
    send_beat(1, 0, 0, 32'h8000_0001);
    send_beat(0, 1, 0, 32'h0000_0000);
    send_beat(0, 1, 0, 32'h0000_0001);
    send_beat(0, 0, 0, 32'h0000_0002);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [31:0] tick_now  [CHANNEL_COUNT];
    logic        want_cool [CHANNEL_COUNT];
    logic        want_heat [CHANNEL_COUNT];
    int          phase;
    int          k;
    int          pick;
    logic        c;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      tick_now[i]  = $urandom_range(1000);
      want_cool[i] = 1'b0;
      want_heat[i] = 1'b0;
    end
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 18; receiver_idle_pct = 86; end
        1: begin sender_idle_pct = 86; receiver_idle_pct = 18; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      for (k = 0; k < RANDOM_BEATS; k++) begin
        if (k % SEGMENT_BEATS == 0) begin
          wait_idle();
          write_reg(CFG_MIN_COOLING, pick_ticks(30));
          write_reg(CFG_MAX_COOLING, pick_ticks(90));
          write_reg(CFG_MIN_OFF, pick_ticks(40));
        end else if (k % SEGMENT_BEATS == 55 || $urandom_range(199) == 0) begin
          wait_idle();
        end
        if ($urandom_range(99) < 8) begin
          // noise: fully random beat
          send_beat(CHANNEL_WIDTH'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), $urandom());
        end else begin
          c = 1'($urandom_range(1));
          if ($urandom_range(99) < 15) begin
            pick = $urandom_range(9);
            want_cool[c] = (pick < 4) || (pick == 9);
            want_heat[c] = (pick >= 4 && pick < 7) || (pick == 9);
          end
          pick = $urandom_range(99);
          if (pick < 3) tick_now[c] = $urandom();
          else if (pick < 5) tick_now[c] = 32'hFFFF_FFFF - $urandom_range(60);
          else tick_now[c] = tick_now[c] + $urandom_range(12);
          send_beat(c, want_cool[c], want_heat[c], tick_now[c]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin : check_results
    guard_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      mode_hits[mode]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: ch %0d mode %0d comp %0d heat %0d",
                   channel_out, mode, compressor_on, heater_on);
      end else begin
        want = pending_results.pop_front();
        if (channel_out !== want.channel || mode !== want.mode ||
            compressor_on !== want.compressor_on || heater_on !== want.heater_on) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result mismatch: expected ch %0d mode %0d comp %0d heat %0d, %s",
                     want.channel, want.mode, want.compressor_on, want.heater_on,
                     $sformatf("got ch %0d mode %0d comp %0d heat %0d",
                               channel_out, mode, compressor_on, heater_on));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = CFG_MIN_COOLING;
    cfg_data          = '0;
    in_valid          = 1'b0;
    channel           = '0;
    cool_request      = 1'b0;
    heat_request      = 1'b0;
    now_ticks         = '0;
    sender_idle_pct   = 18;
    receiver_idle_pct = 86;
    beats_sent        = 0;
    reg_writes        = 0;
    run_min  = MIN_COOLING_RESET;
    run_max  = MAX_COOLING_RESET;
    rest_min = MIN_OFF_RESET;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      chan_mode[i]    = MODE_OFF;
      cool_open_at[i] = '0;
      run_until[i]    = '0;
      run_cutoff[i]   = '0;
      heat_open_at[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_special_cases();
    test_register_extremes();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d input beats, %0d result beats, %0d register writes",
             beats_sent, results_seen, reg_writes);
    $display("modes seen: off %0d, cool wait %0d, cooling %0d, overrun %0d, %s",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
             $sformatf("heat wait %0d, heating %0d", mode_hits[4], mode_hits[5]));
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/chg_pkg.sv
sv/chg_ram.sv
sv/chg_update.sv
sv/compressor_heater_guard_fsm.sv
dv/tb.sv
